>>> rtl/touch_axis_median_filter_macros.svh
// Assertion macros for the touch axis median filter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TOUCH_AXIS_MEDIAN_FILTER_MACROS_SVH
`define TOUCH_AXIS_MEDIAN_FILTER_MACROS_SVH

// Assert a property on every rising clock edge outside reset
`define TAMF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that a condition never holds outside reset
`define TAMF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/tamf_pkg.sv
// Shared constants and types for the touch axis median filter.
// No dependencies; imported by every module of the block.
package tamf_pkg;

	// Window length and sample width
	localparam int WINDOW      = 5;
	localparam int SAMPLE_BITS = 12;

	// Derived widths
	localparam int CNT_W   = $clog2(WINDOW);
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CNT_W-1:0]       rank_t;
	typedef sample_t [WINDOW-1:0]   window_t;
	typedef sample_t [WINDOW-2:0]   partial_t;

	// Rank of the median and index of the last sample of a window
	localparam rank_t MID_RANK  = rank_t'(WINDOW / 2);
	localparam rank_t FILL_LAST = rank_t'(WINDOW - 1);

	// Axis codes
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

endpackage

>>> rtl/tamf_median.sv
// Rank-based median selector for one full window of samples.
// Depends on tamf_pkg for the window type and median rank.
module tamf_median
	import tamf_pkg::*;
(
	input  window_t win,
	output sample_t median
);

	// Rank each entry (ties broken by position) and pick the middle rank
	always_comb begin
		rank_t rank [WINDOW];
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i) begin
					if (win[j] < win[i] || (win[j] == win[i] && j < i)) begin
						rank[i] = rank[i] + rank_t'(1);
					end
				end
			end
			if (rank[i] == MID_RANK) begin
				median = win[i];
			end
		end
	end

endmodule

>>> rtl/touch_axis_median_filter.sv
// Path: the fifth sample of a window loads the snapshot register, and the combinational
// rank network feeds the result register on m_axis. Throughput: one sample per cycle while
// s_axis_tready is high; one median per five samples, set by the window register.
// Reset: fill count, axis (starts at X) and both valid flags clear; sample registers hold
// whatever they had and are always refilled before use.
module touch_axis_median_filter
	import tamf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // [11:0] sample
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // [11:0] median_value
	output logic               m_axis_tuser   // [0] axis (0 = X, 1 = Y)
);

`include "touch_axis_median_filter_macros.svh"

	rank_t    fill_q;
	logic     axis_q;
	partial_t win_q;

	logic     valid_s1;
	window_t  win_s1;
	logic     axis_s1;

	logic     out_valid_q;
	sample_t  median_q;
	logic     out_axis_q;

	sample_t  sample;
	sample_t  median;
	logic     s_beat;
	logic     last;
	logic     adv;

	assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
	assign last   = (fill_q == FILL_LAST);
	assign adv    = valid_s1 && (!out_valid_q || m_axis_tready);
	// Only the closing sample of a window needs room in the snapshot stage
	assign s_axis_tready = !last || !valid_s1 || adv;
	assign s_beat        = s_axis_tvalid && s_axis_tready;

	// Count samples and toggle the axis at each window end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			axis_q <= AXIS_X;
		end else if (s_beat) begin
			if (last) begin
				fill_q <= '0;
				axis_q <= ~axis_q;
			end else begin
				fill_q <= fill_q + rank_t'(1);
			end
		end
	end

	// Shift samples into the partial window
	always_ff @(posedge clk) begin
		if (s_beat) begin
			win_q <= {sample, win_q[WINDOW-2:1]};
		end
	end

	// Snapshot stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_beat && last) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the full window with its closing sample
	always_ff @(posedge clk) begin
		if (s_beat && last) begin
			win_s1  <= {sample, win_q};
			axis_s1 <= axis_q;
		end
	end

	tamf_median u_median (
		.win    (win_s1),
		.median (median)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the median until the beat is taken
	always_ff @(posedge clk) begin
		if (adv) begin
			median_q   <= median;
			out_axis_q <= axis_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(median_q);
	assign m_axis_tuser  = out_axis_q;

	// Checks
	`TAMF_NEVER(a_fill_range, fill_q > FILL_LAST, "fill count beyond window")
	`TAMF_ASSERT(a_axis_toggle, s_beat && last |=> axis_q != $past(axis_q), "axis did not toggle")
	`TAMF_ASSERT(a_axis_hold, !(s_beat && last) |=> $stable(axis_q), "axis changed mid-window")
	`TAMF_ASSERT(a_snap_load, s_beat && last |=> valid_s1, "window snapshot not loaded")
	`TAMF_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(valid_s1), "result without snapshot")

endmodule

>>> tb/tamf_median_check.sv
// Scoreboard for the touch axis median filter: watches both stream channels,
// predicts each median from the accepted samples and compares every result beat.
// Depends on tamf_pkg for widths, the sample type and the axis codes.
module tamf_median_check
	import tamf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [11:0] sample
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [11:0] median_value
	input  logic               m_tuser,   // [0] axis
	output int                 due_count,
	output int                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sample_t value;
		logic    axis;
	} median_beat_t;

	median_beat_t medians_due [$];
	median_beat_t oldest;
	window_t      held;
	int           fill;
	logic         axis_now;
	int           errors = 0;

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Rank the window ascending and take the middle entry; ties rank as equal values
	function automatic sample_t middle_of(input window_t w);
		sample_t ord [WINDOW];
		sample_t v;
		int      k;
		for (int n = 0; n < WINDOW; n++)
			ord[n] = w[n];
		for (int n = 1; n < WINDOW; n++) begin
			v = ord[n];
			k = n;
			while (k > 0 && ord[k-1] > v) begin
				ord[k] = ord[k-1];
				k--;
			end
			ord[k] = v;
		end
		return ord[MID_RANK];
	endfunction

	// Compare result beats first, then absorb the sample beat of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			medians_due.delete();
			fill       = 0;
			axis_now   = AXIS_X;
			due_count  <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (medians_due.size() == 0) begin
					report_mismatch($sformatf("median beat %0d axis %b with none due",
						m_tdata[SAMPLE_BITS-1:0], m_tuser));
				end else begin
					oldest = medians_due.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== oldest.value)
						report_mismatch($sformatf("median_value %0d, predicted %0d",
							m_tdata[SAMPLE_BITS-1:0], oldest.value));
					if (m_tuser !== oldest.axis)
						report_mismatch($sformatf("axis %b, predicted %b",
							m_tuser, oldest.axis));
				end
			end
			// Bits above the sample width are dropped
			if (s_tvalid && s_tready) begin
				held[fill] = s_tdata[SAMPLE_BITS-1:0];
				if (fill == WINDOW - 1) begin
					medians_due.push_back('{value: middle_of(held), axis: axis_now});
					fill     = 0;
					axis_now = (axis_now == AXIS_X) ? AXIS_Y : AXIS_X;
				end else begin
					fill++;
				end
			end
			due_count  <= medians_due.size();
			fail_count <= errors;
		end
	end

endmodule

>>> tb/tb.sv
// Top of the median filter testbench: clock, reset, sample and ready stimulus, verdict.
// Instantiates touch_axis_median_filter beside tamf_median_check; uses tamf_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tamf_pkg::*;

	typedef logic [TDATA_W-1:0] word_t;

	typedef enum int {
		SHAPE_UNIFORM,
		SHAPE_CLUSTER,
		SHAPE_TIES,
		SHAPE_RAILS
	} window_shape_t;

	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PHASES       = 4;
	localparam int PHASE_WINDOWS = 65;
	localparam int DIRECTED_LEN = 25;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	word_t              s_axis_tdata;   // [11:0] sample
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	word_t              m_axis_tdata;   // [11:0] median_value
	logic               m_axis_tuser;   // [0] axis (0 = X, 1 = Y)

	int                 due_count;
	int                 fail_count;
	int                 idle_cycles = 0;
	int unsigned        send_gap_max = 8;
	int unsigned        ready_gap_max = 8;

	// Directed windows: all zero, all full scale, descending extremes,
	// ties around the middle, and rails plus a mid value with junk above the sample bits
	word_t directed_words [DIRECTED_LEN] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0fff, 16'h0fff, 16'h0fff, 16'h0fff, 16'h0fff,
		16'h0fff, 16'h0bb8, 16'h0800, 16'h0001, 16'h0000,
		16'h0007, 16'h0007, 16'h0003, 16'h0007, 16'h0009,
		16'hf000, 16'h0fff, 16'hf000, 16'h8fff, 16'h5555
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	touch_axis_median_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	tamf_median_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.due_count  (due_count),
		.fail_count (fail_count)
	);

	// Abort when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stall the result channel a random number of cycles before each beat
	initial begin
		int unsigned gap;
		m_axis_tready = 1'b0;
		forever begin
			gap = $urandom_range(0, ready_gap_max);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_axis_tvalid));
		end
	end

	// Idle a random number of cycles, then hold one sample beat until taken
	task automatic send_sample(input word_t word);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off the sample channel until every predicted median has been seen
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	// Build one sample word of a window; now and then set the bits above the sample
	function automatic word_t draw_word(input window_shape_t shape, input int base, input int alt);
		int    v;
		word_t w;
		case (shape)
			SHAPE_UNIFORM: v = $urandom_range(0, 4095);
			SHAPE_CLUSTER: begin
				v = base + $urandom_range(0, 64) - 32;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
			SHAPE_TIES:    v = $urandom_range(0, 1) ? base : alt;
			default: begin
				case ($urandom_range(0, 3))
					0:       v = 0;
					1:       v = 1;
					2:       v = 4094;
					default: v = 4095;
				endcase
			end
		endcase
		w = word_t'(v);
		if ($urandom_range(0, 3) == 0)
			w[TDATA_W-1:SAMPLE_BITS] = (TDATA_W-SAMPLE_BITS)'($urandom());
		return w;
	endfunction

	initial begin
		window_shape_t shape;
		int            base;
		int            alt;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed windows
		foreach (directed_words[i])
			send_sample(directed_words[i]);
		hold_until_drained();

		// Random windows, one idling profile per phase
		for (int p = 0; p < PHASES; p++) begin
			send_gap_max  = (p == 1 || p == 2) ? 0 : 8;
			ready_gap_max = (p == 1 || p == 3) ? 0 : 8;
			for (int n = 0; n < PHASE_WINDOWS; n++) begin
				shape = window_shape_t'($urandom_range(0, 3));
				base  = $urandom_range(0, 4095);
				alt   = $urandom_range(0, 4095);
				for (int k = 0; k < WINDOW; k++)
					send_sample(draw_word(shape, base, alt));
			end
			hold_until_drained();
		end

		// Let any stray result beat show up before the verdict
		ready_gap_max = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tamf_pkg.sv
rtl/tamf_median.sv
rtl/touch_axis_median_filter.sv
tb/tamf_median_check.sv
tb/tb.sv
